### rtl/fimt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fimt_pkg: shared types and constants of the forbidden-interval max time block
// Field widths, function codes, the stored entry layout and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fimt_pkg;

    localparam int TIME_W       = 32;   // unsigned Q16.16
    localparam int AXIS_W       = 4;    // width of the axis fields of an item
    localparam int MAX_AXES_DEF = 16;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] min_time;
        logic [TIME_W-1:0] forbid_low;
        logic [TIME_W-1:0] forbid_high;
    } fimt_entry_t;

    typedef struct packed {
        logic write_en;     // store the entry of the accepted item
        logic query_load;   // latch the range of the accepted query
        logic scan_start;   // restart the range scan at its first axis
        logic max_en;       // scan result feeds the running maximum
        logic raise_en;     // scan result raises the time out of intervals
        logic out_load;     // move the final time into the output register
    } fimt_cmd_t;

    typedef struct packed {
        logic is_query;     // offered item is a query
        logic empty;        // latched range holds no axis
        logic scan_last;    // scan data of the last axis of the range is valid
        logic hit;          // scan data holds the current time inside its interval
    } fimt_status_t;

endpackage
`default_nettype wire

### rtl/fimt_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fimt_in_if: input channel of the forbidden-interval max time block
// Carries one write or query item with a valid / ready handshake.
// ----------------------------------------------------------------------------
interface fimt_in_if;
    import fimt_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [AXIS_W-1:0] axis_index;
    logic [TIME_W-1:0] min_time;
    logic [TIME_W-1:0] forbid_low;
    logic [TIME_W-1:0] forbid_high;
    logic [AXIS_W-1:0] range_first;
    logic [AXIS_W-1:0] range_last;

    modport source (
        output valid, func, axis_index, min_time, forbid_low, forbid_high,
               range_first, range_last,
        input  ready
    );

    modport sink (
        input  valid, func, axis_index, min_time, forbid_low, forbid_high,
               range_first, range_last,
        output ready
    );

endinterface
`default_nettype wire

### rtl/fimt_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fimt_out_if: result channel of the forbidden-interval max time block
// Carries one query result item with a valid / ready handshake.
// ----------------------------------------------------------------------------
interface fimt_out_if;
    import fimt_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] combined_time;
    logic              empty_range;

    modport source (
        output valid, combined_time, empty_range,
        input  ready
    );

    modport sink (
        input  valid, combined_time, empty_range,
        output ready
    );

endinterface
`default_nettype wire

### rtl/forbidden_interval_max_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// forbidden_interval_max_time: range maximum time raised past forbidden gaps
// A write item stores one axis entry (minimum time and forbidden open
// interval); a query item returns the largest minimum time over an axis
// range, raised past every forbidden interval of that range that holds it.
// ----------------------------------------------------------------------------
// The block is taken one item at a time. A write item is accepted and
// returns nothing; writes to an axis at or past MAX_AXES are dropped. A
// query over an empty range (range_first past range_last, with range_last
// clamped to MAX_AXES - 1) returns time zero with empty_range set. A query
// first reads the table once to find the largest minimum time, then scans
// the range for a forbidden interval holding that time; each hit raises the
// time to that interval's upper end and restarts the scan at the first axis,
// and a full scan without a hit ends the query. The single read port of the
// entry table delivers one axis per cycle through its registered read. All
// times are unsigned Q16.16 and only compared and copied, so results are
// exact. The entry table has no reset: querying an axis that was never
// written gives an undefined time. The result sits in an output register,
// so the next item is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module forbidden_interval_max_time #(
    parameter int MAX_AXES = fimt_pkg::MAX_AXES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fimt_in_if.sink   request,
    fimt_out_if.source result
);
    import fimt_pkg::*;

    fimt_cmd_t    cmd;
    fimt_status_t status;
    logic         ctl_in_ready;
    logic         ctl_out_valid;

    // The controller sequences the work; it sees only the handshake signals
    // and the status bundle from the datapath.
    fimt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (ctl_in_ready),
        .out_valid (ctl_out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the entry table, the scan and the output payload.
    fimt_datapath #(
        .MAX_AXES (MAX_AXES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (request.func),
        .axis_index    (request.axis_index),
        .min_time      (request.min_time),
        .forbid_low    (request.forbid_low),
        .forbid_high   (request.forbid_high),
        .range_first   (request.range_first),
        .range_last    (request.range_last),
        .combined_time (result.combined_time),
        .empty_range   (result.empty_range)
    );

    assign request.ready = ctl_in_ready;
    assign result.valid  = ctl_out_valid;

endmodule
`default_nettype wire

### rtl/fimt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fimt_datapath: entry table, range scan and time register
// Holds the axis entries in a memory with a registered read port, walks the
// latched range one axis per cycle and keeps the running time.
// ----------------------------------------------------------------------------
module fimt_datapath #(
    parameter int MAX_AXES = fimt_pkg::MAX_AXES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fimt_pkg::fimt_cmd_t         cmd,
    output fimt_pkg::fimt_status_t           status,
    input  wire logic                        func,
    input  wire logic [fimt_pkg::AXIS_W-1:0] axis_index,
    input  wire logic [fimt_pkg::TIME_W-1:0] min_time,
    input  wire logic [fimt_pkg::TIME_W-1:0] forbid_low,
    input  wire logic [fimt_pkg::TIME_W-1:0] forbid_high,
    input  wire logic [fimt_pkg::AXIS_W-1:0] range_first,
    input  wire logic [fimt_pkg::AXIS_W-1:0] range_last,
    output logic      [fimt_pkg::TIME_W-1:0] combined_time,
    output logic                             empty_range
);
    import fimt_pkg::*;

    localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int CMP_W = ((IDX_W > AXIS_W) ? IDX_W : AXIS_W) + 1;
    localparam logic [CMP_W-1:0] LAST_AXIS = CMP_W'(MAX_AXES - 1);

    fimt_entry_t mem [MAX_AXES];

    logic [IDX_W-1:0]  first_reg, last_reg, addr_reg;
    logic              empty_reg;
    logic              issue_reg, dvalid_reg, dfirst_reg, dlast_reg;
    fimt_entry_t       rd_data_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_empty_reg;

    logic [CMP_W-1:0]  index_c, first_c, last_c, last_sat_c;
    logic              index_ok, do_read, hit;

    always_comb
    begin
        index_c    = CMP_W'(axis_index);
        first_c    = CMP_W'(range_first);
        last_c     = CMP_W'(range_last);
        last_sat_c = (last_c > LAST_AXIS) ? LAST_AXIS : last_c;
        index_ok   = (index_c <= LAST_AXIS);
        do_read    = issue_reg && !cmd.scan_start;
        hit        = dvalid_reg && (t_reg > rd_data_reg.forbid_low)
                     && (t_reg < rd_data_reg.forbid_high);
    end

    assign status.is_query  = (func == FUNC_QUERY);
    assign status.empty     = empty_reg;
    assign status.scan_last = dvalid_reg && dlast_reg;
    assign status.hit       = hit;

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && index_ok)
        begin
            mem[IDX_W'(index_c)] <= '{min_time, forbid_low, forbid_high};
        end
        if (do_read)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Scan sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            dvalid_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            issue_reg  <= 1'b1;
            dvalid_reg <= 1'b0;
        end
        else
        begin
            dvalid_reg <= issue_reg;
            if (issue_reg && (addr_reg == last_reg))
            begin
                issue_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_load)
        begin
            first_reg <= IDX_W'(first_c);
            last_reg  <= IDX_W'(last_sat_c);
            empty_reg <= (first_c > last_sat_c);
        end

        if (cmd.scan_start)
        begin
            addr_reg <= first_reg;
        end
        else if (do_read)
        begin
            dfirst_reg <= (addr_reg == first_reg);
            dlast_reg  <= (addr_reg == last_reg);
            if (addr_reg != last_reg)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
        end

        // The first axis seeds the maximum; a strict compare keeps ties.
        if (cmd.max_en && dvalid_reg)
        begin
            if (dfirst_reg || (rd_data_reg.min_time > t_reg))
            begin
                t_reg <= rd_data_reg.min_time;
            end
        end
        else if (cmd.raise_en && hit)
        begin
            t_reg <= rd_data_reg.forbid_high;
        end

        if (cmd.out_load)
        begin
            out_time_reg  <= empty_reg ? '0 : t_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign combined_time = out_time_reg;
    assign empty_range   = out_empty_reg;

endmodule
`default_nettype wire

### rtl/fimt_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fimt_controller: sequencer of the forbidden-interval max time block
// Takes items, runs the maximum scan and the raise scans, and owns the valid
// flag of the output register.
// ----------------------------------------------------------------------------
module fimt_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire fimt_pkg::fimt_status_t status,
    output fimt_pkg::fimt_cmd_t         cmd
);
    import fimt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_MAX   = 5'b00100,
        ST_RAISE = 5'b01000,
        ST_DONE  = 5'b10000
    } fimt_state_t;

    fimt_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.is_query)
                    begin
                        cmd.query_load = 1'b1;
                        state_next     = ST_START;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                if (status.empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_MAX;
                end
            end
            ST_MAX:
            begin
                cmd.max_en = 1'b1;
                if (status.scan_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_RAISE;
                end
            end
            ST_RAISE:
            begin
                cmd.raise_en = 1'b1;
                if (status.hit)
                begin
                    cmd.scan_start = 1'b1;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted query always moves on to the range check.
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.is_query) |=> (state_reg == ST_START))
        else $error("accepted query did not start");

    // A new result appears only as the controller leaves the done state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    // A finished query waits while the previous result is still held.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && !out_ready)
        |=> ((state_reg == ST_DONE) && out_valid_reg))
        else $error("held result overwritten");

    // Scans are never started over an empty range.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> !status.empty)
        else $error("scan started over an empty range");

endmodule
`default_nettype wire

### verif/fimt_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fimt_result_check: result prediction and comparison for the max time block
// Watches both channels. It keeps its own copy of the axis table and
// computes the expected result of every accepted query. It compares each
// accepted result field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module fimt_result_check #(
    parameter int MAX_AXES = fimt_pkg::MAX_AXES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fimt_in_if        request,
    fimt_out_if       result,
    output int        errors,
    output int        pending
);
    import fimt_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0] combined_time;
        logic              empty_range;
    } query_result_t;

    logic [TIME_W-1:0] axis_min_time [MAX_AXES];
    logic [TIME_W-1:0] axis_gap_low  [MAX_AXES];
    logic [TIME_W-1:0] axis_gap_high [MAX_AXES];

    query_result_t expected_times [$];
    int            fail_count  = 0;
    int            outstanding = 0;

    assign errors  = fail_count;
    assign pending = outstanding;

    // Largest minimum time of the range, then raised to the upper end of the
    // first interval (lowest axis) that holds it, until none does.
    function automatic query_result_t predict_query(input logic [AXIS_W-1:0] first_ax,
                                                    input logic [AXIS_W-1:0] last_ax);
        query_result_t     r;
        int                lo;
        int                hi;
        int                k;
        int                rounds;
        logic [TIME_W-1:0] t;
        logic              hit;
        logic              settled;

        lo = int'(first_ax);
        hi = (int'(last_ax) > MAX_AXES - 1) ? MAX_AXES - 1 : int'(last_ax);
        r.combined_time = '0;
        r.empty_range   = 1'b1;
        if (lo > hi)
            return r;

        t = axis_min_time[lo];
        for (k = lo + 1; k <= hi; k++)
            if (axis_min_time[k] > t)
                t = axis_min_time[k];

        settled = 1'b0;
        for (rounds = 0; rounds <= MAX_AXES && !settled; rounds++)
        begin
            hit = 1'b0;
            for (k = lo; k <= hi && !hit; k++)
            begin
                if (t > axis_gap_low[k] && t < axis_gap_high[k])
                begin
                    t   = axis_gap_high[k];
                    hit = 1'b1;
                end
            end
            settled = !hit;
        end

        r.combined_time = t;
        r.empty_range   = 1'b0;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        query_result_t want;

        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (expected_times.size() == 0)
                begin
                    $error("result with no query waiting: combined_time %h, empty_range %b",
                           result.combined_time, result.empty_range);
                    fail_count++;
                end
                else
                begin
                    want = expected_times.pop_front();
                    if (result.combined_time !== want.combined_time)
                    begin
                        $error("combined_time: expected %h, actual %h",
                               want.combined_time, result.combined_time);
                        fail_count++;
                    end
                    if (result.empty_range !== want.empty_range)
                    begin
                        $error("empty_range: expected %b, actual %b",
                               want.empty_range, result.empty_range);
                        fail_count++;
                    end
                end
            end

            if (request.valid && request.ready)
            begin
                if (request.func == FUNC_WRITE)
                begin
                    // Writes past the table are dropped by the block.
                    if (int'(request.axis_index) < MAX_AXES)
                    begin
                        axis_min_time[request.axis_index] = request.min_time;
                        axis_gap_low[request.axis_index]  = request.forbid_low;
                        axis_gap_high[request.axis_index] = request.forbid_high;
                    end
                end
                else
                    expected_times.push_back(predict_query(request.range_first,
                                                           request.range_last));
            end

            outstanding = expected_times.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the forbidden-interval max time block
// Fills the whole axis table, runs directed queries over the corner cases,
// then a long random mix of writes and queries with random gaps on both
// channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import fimt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RANDOM_ITEMS  = 900;
    localparam int IDLE_PERCENT  = 29;
    // Items inside this window are offered with no gaps and results are taken with no stalls.
    localparam int CALM_FIRST    = 300;
    localparam int CALM_LAST     = 450;
    // Once this many items are in, the result side holds off for a while.
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 300;
    // At this item the input side waits until every result has come back.
    localparam int DRAIN_AT      = 750;
    // The limit is many times the slowest correct run including gaps and
    // the long hold.
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [TIME_W-1:0] HALF_UNIT = 32'h0000_8000;   // 0.5 in Q16.16

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int items_sent = 0;   // items accepted by the block so far
    bit calm       = 1'b0;
    int fail_count;
    int queries_open;

    fimt_in_if  request ();
    fimt_out_if result ();

    forbidden_interval_max_time i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    fimt_result_check i_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result),
        .errors  (fail_count),
        .pending (queries_open)
    );

    always #CLK_HALF clk = ~clk;

    // Times mostly sit on a coarse grid of half units so that minimum times
    // often land inside forbidden intervals and chains of raises build up.
    // The extremes and full random words make every bit toggle.
    function automatic logic [TIME_W-1:0] rand_time();
        case ($urandom_range(9))
            0:       rand_time = '0;
            1:       rand_time = '1;
            2, 3:    rand_time = $urandom();
            default: rand_time = $urandom_range(48) * HALF_UNIT;
        endcase
    endfunction

    // Upper end of an interval: mostly a few grid steps above the low end,
    // sometimes equal (empty interval) or unrelated (often inverted).
    function automatic logic [TIME_W-1:0] rand_upper(input logic [TIME_W-1:0] low_end);
        case ($urandom_range(9))
            0:       rand_upper = low_end;
            1:       rand_upper = rand_time();
            default: rand_upper = low_end + $urandom_range(1, 8) * HALF_UNIT;
        endcase
    endfunction

    // Offers one item starting at a falling edge and returns at the falling
    // edge after it was taken. Valid stays high into the next item unless a
    // gap is drawn, so back-to-back items really are back to back.
    task automatic offer(input logic              func,
                         input logic [AXIS_W-1:0] axis,
                         input logic [TIME_W-1:0] min_t,
                         input logic [TIME_W-1:0] low_end,
                         input logic [TIME_W-1:0] high_end,
                         input logic [AXIS_W-1:0] first_ax,
                         input logic [AXIS_W-1:0] last_ax);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid       <= 1'b1;
        request.func        <= func;
        request.axis_index  <= axis;
        request.min_time    <= min_t;
        request.forbid_low  <= low_end;
        request.forbid_high <= high_end;
        request.range_first <= first_ax;
        request.range_last  <= last_ax;
        do
            @(posedge clk);
        while (!request.ready);
        items_sent++;
        calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
        @(negedge clk);
    endtask

    // The range fields of a write and the time fields of a query carry
    // random noise; the block must ignore them.
    task automatic store_axis(input logic [AXIS_W-1:0] axis,
                              input logic [TIME_W-1:0] min_t,
                              input logic [TIME_W-1:0] low_end,
                              input logic [TIME_W-1:0] high_end);
        offer(FUNC_WRITE, axis, min_t, low_end, high_end,
              AXIS_W'($urandom_range(15)), AXIS_W'($urandom_range(15)));
    endtask

    task automatic query_range(input logic [AXIS_W-1:0] first_ax,
                               input logic [AXIS_W-1:0] last_ax);
        offer(FUNC_QUERY, AXIS_W'($urandom_range(15)), $urandom(), $urandom(), $urandom(),
              first_ax, last_ax);
    endtask

    // Stimulus. The table has no reset, so every axis is written before the
    // first query that reads it; from then on any range is legal.
    initial
    begin
        logic [AXIS_W-1:0] first_ax;
        logic [AXIS_W-1:0] last_ax;
        logic [AXIS_W-1:0] swap_ax;
        logic [TIME_W-1:0] low_end;

        request.valid       = 1'b0;
        request.func        = FUNC_WRITE;
        request.axis_index  = '0;
        request.min_time    = '0;
        request.forbid_low  = '0;
        request.forbid_high = '0;
        request.range_first = '0;
        request.range_last  = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Axis 0 is all zero with a zero-width interval; axis 1 holds the top
        // time next to an interval that ends exactly on it.
        store_axis(4'd0, '0, '0, '0);
        store_axis(4'd1, '1, 32'hFFFF_FFFE, '1);
        // Axes 2 to 7 form a chain: 5.0 (tied on axes 2 and 3) is raised to
        // 6.0, 8.0, 9.0 and finally 10.0; the scan restarts after each raise.
        // Axis 6 has an inverted interval and axis 7 an empty one.
        store_axis(4'd2, 10 * HALF_UNIT,  8 * HALF_UNIT, 12 * HALF_UNIT);
        store_axis(4'd3, 10 * HALF_UNIT, 11 * HALF_UNIT, 16 * HALF_UNIT);
        store_axis(4'd4,  6 * HALF_UNIT, 14 * HALF_UNIT, 18 * HALF_UNIT);
        store_axis(4'd5,  2 * HALF_UNIT, 17 * HALF_UNIT, 20 * HALF_UNIT);
        store_axis(4'd6,  4 * HALF_UNIT, 24 * HALF_UNIT, 22 * HALF_UNIT);
        store_axis(4'd7,  1 * HALF_UNIT, 20 * HALF_UNIT, 20 * HALF_UNIT);
        for (int k = 8; k < 14; k++)
        begin
            low_end = rand_time();
            store_axis(AXIS_W'(k), rand_time(), low_end, rand_upper(low_end));
        end
        // Axis 14: the smallest nonzero time inside the widest interval, so
        // it is raised all the way to the top. Axis 15: just below a boundary.
        store_axis(4'd14, 32'h0000_0001, '0, '1);
        store_axis(4'd15, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'h8000_0000);

        query_range(4'd15, 4'd0);    // empty range
        query_range(4'd15, 4'd15);
        query_range(4'd14, 4'd14);
        query_range(4'd0, 4'd0);
        query_range(4'd1, 4'd1);
        query_range(4'd2, 4'd3);     // tie on the maximum
        query_range(4'd2, 4'd7);     // chain of raises
        query_range(4'd6, 4'd7);     // only intervals that never hold a time
        query_range(4'd0, 4'd15);    // whole table

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (items_sent == DRAIN_AT)
            begin
                // Let the block run dry before going on.
                request.valid <= 1'b0;
                wait (queries_open == 0);
                @(negedge clk);
            end

            if ($urandom_range(99) < 35)
            begin
                low_end = rand_time();
                store_axis(AXIS_W'($urandom_range(15)), rand_time(), low_end,
                           rand_upper(low_end));
            end
            else
            begin
                first_ax = AXIS_W'($urandom_range(15));
                last_ax  = AXIS_W'($urandom_range(15));
                // Most queries cover a real range; the rest stay as drawn
                // and are empty about half of the time.
                if ($urandom_range(99) < 80 && first_ax > last_ax)
                begin
                    swap_ax  = first_ax;
                    first_ax = last_ax;
                    last_ax  = swap_ax;
                end
                query_range(first_ax, last_ax);
            end
        end

        request.valid <= 1'b0;
        wait (queries_open == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Result side: random stalls, none in the calm window, and one long hold
    // during which the block fills up and stops taking items.
    initial
    begin
        bit held;

        held         = 1'b0;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && items_sent >= HOLD_AT)
            begin
                held = 1'b1;
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                result.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        int cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/fimt_pkg.sv
rtl/fimt_in_if.sv
rtl/fimt_out_if.sv
rtl/fimt_datapath.sv
rtl/fimt_controller.sv
rtl/forbidden_interval_max_time.sv
verif/fimt_result_check.sv
verif/tb_top.sv
